// File: design/plie_pkg.sv
package plie_pkg;

   localparam int DEPTH  = 128;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
   localparam int WORD_W = 64;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   localparam logic [7:0] CAP_RESET = 8'd99;

endpackage

// File: design/positional_list_insert_erase.sv
// Bounded 1-based list of 64-bit words with insert, erase and read. Each
// request transfer carries an op code in tuser and a position and word in
// tdata; each one produces exactly one response transfer with the word read
// (zero unless a read succeeds), the list length after the operation and a
// status (ok, full, bad position, empty). The entries live in a single
// 128 x 64 memory with one write and one registered read port, and one
// shared move step carries an entry from one slot to its neighbor: a fetch
// in S_RD, then a write in S_WR. A refused or empty-handed operation goes to
// S_DONE directly, a read through S_RDW, an erase takes one move step per
// entry shifted down, and an insert one per entry shifted up (entries after
// the position) before S_PUT. The request side is ready only while the sequencer
// is idle; the response sits in an output register, so the next request can
// be taken while the previous response still waits. The capacity register
// (reset 99, clamped to the memory depth) is written via csr_we, csr_wdata;
// the user must write it only while the block is idle; no check enforces it.
// Memory contents are undefined after reset; only written slots are ever read.
module positional_list_insert_erase
   import plie_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // config: capacity_limit
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [7:0] position, [71:8] value
   input  logic [1:0]  req_tuser,   // [1:0] op
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [63:0] read_value, [71:64] length,
                                    // [73:72] status, [79:74] zero
);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;  // fetch the entry to move
   localparam logic [2:0] S_WR   = 3'd2;  // write it one slot over
   localparam logic [2:0] S_PUT  = 3'd3;  // store the inserted word
   localparam logic [2:0] S_RDW  = 3'd4;  // capture a read op's data
   localparam logic [2:0] S_DONE = 3'd5;  // hand result to output register

   logic [2:0]        state_ff, state_in;
   logic [7:0]        cap_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  cnt_new_ff, cnt_new_in;
   logic [CNT_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]  slot_ff, slot_in;
   logic [1:0]        op_ff, op_in;
   logic [1:0]        status_ff, status_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic [WORD_W-1:0] rd_ff, rd_in;
   logic              rsp_valid_ff;
   logic [79:0]       rsp_data_ff;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  raddr, waddr;
   logic [WORD_W-1:0] wdata;
   logic              mem_we;

   logic [7:0]        req_pos;
   logic [WORD_W-1:0] req_value;
   logic [1:0]        req_op;
   logic              req_fire, load_rsp;

   logic [CMP_W-1:0]  pos_x, cnt_x, lim_x, pm1_x, ers_x;
   logic [CNT_W-1:0]  cur_dec, cur_inc;

   assign req_pos   = req_tdata[7:0];
   assign req_value = req_tdata[71:8];
   assign req_op    = req_tuser;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_rsp   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // widened operands for position and limit checks
   assign pos_x = CMP_W'(req_pos);
   assign cnt_x = CMP_W'(count_ff);
   assign lim_x = (CMP_W'(cap_ff) < CMP_W'(DEPTH)) ? CMP_W'(cap_ff) : CMP_W'(DEPTH);
   assign pm1_x = pos_x - CMP_W'(1);
   // erase slot: clamp position to 1..count, then drop to 0-based
   always_comb begin
      priority if (pos_x == '0) begin
         ers_x = '0;
      end else if (pos_x > cnt_x) begin
         ers_x = cnt_x - CMP_W'(1);
      end else begin
         ers_x = pm1_x;
      end
   end

   assign cur_dec = cur_ff - CNT_W'(1);
   assign cur_inc = cur_ff + CNT_W'(1);

   // memory address and write selection
   always_comb begin
      raddr  = IDX_W'(pm1_x);
      waddr  = IDX_W'(cur_ff);
      wdata  = rdata_ff;
      mem_we = 1'b0;
      unique case (state_ff)
         S_RD: begin
            raddr = (op_ff == OP_INSERT) ? IDX_W'(cur_dec) : IDX_W'(cur_inc);
         end
         S_WR: begin
            mem_we = 1'b1;
         end
         S_PUT: begin
            waddr  = IDX_W'(slot_ff);
            wdata  = value_ff;
            mem_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cnt_new_in = cnt_new_ff;
      cur_in     = cur_ff;
      slot_in    = slot_ff;
      op_in      = op_ff;
      status_in  = status_ff;
      value_in   = value_ff;
      rd_in      = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in      = req_op;
               value_in   = req_value;
               rd_in      = '0;
               status_in  = ST_OK;
               cnt_new_in = count_ff;
               state_in   = S_DONE;
               unique case (req_op)
                  OP_INSERT: begin
                     priority if (cnt_x >= lim_x) begin
                        status_in = ST_FULL;
                     end else if (pos_x == '0) begin
                        status_in = ST_BADPOS;
                     end else begin
                        // append when the position lies beyond the end
                        slot_in    = (pm1_x > cnt_x) ? count_ff : CNT_W'(pm1_x);
                        cur_in     = count_ff;
                        cnt_new_in = count_ff + CNT_W'(1);
                        state_in   = (count_ff > slot_in) ? S_RD : S_PUT;
                     end
                  end
                  OP_ERASE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        slot_in    = CNT_W'(ers_x);
                        cur_in     = CNT_W'(ers_x);
                        cnt_new_in = count_ff - CNT_W'(1);
                        state_in   = ((CNT_W'(ers_x) + CNT_W'(1)) < count_ff) ? S_RD : S_DONE;
                     end
                  end
                  OP_READ: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = ST_BADPOS;
                     end else begin
                        state_in = S_RDW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            // advance the cursor one slot toward the end of the move
            if (op_ff == OP_INSERT) begin
               cur_in   = cur_dec;
               state_in = (cur_dec > slot_ff) ? S_RD : S_PUT;
            end else begin
               cur_in   = cur_inc;
               state_in = ((cur_inc + CNT_W'(1)) < count_ff) ? S_RD : S_DONE;
            end
         end
         S_PUT: begin
            state_in = S_DONE;
         end
         S_RDW: begin
            rd_in    = rdata_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               count_in = cnt_new_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         // hold the response until the consumer takes it
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_new_ff <= cnt_new_in;
      cur_ff     <= cur_in;
      slot_ff    <= slot_in;
      op_ff      <= op_in;
      status_ff  <= status_in;
      value_ff   <= value_in;
      rd_ff      <= rd_in;
      if (load_rsp) begin
         rsp_data_ff <= {6'd0, status_ff, 8'(cnt_new_ff), rd_ff};
      end
   end

   // the list never holds more entries than the memory has slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count beyond memory depth");

   // an upward move only runs while the cursor is above the insert slot
   a_ins_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && op_ff == OP_INSERT) |-> (cur_ff > slot_ff))
      else $error("insert move past its slot");

   // the count changes only when a result is handed to the output
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !load_rsp |=> $stable(count_ff))
      else $error("count changed without a response");

   // an accepted request always leaves the idle state
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("request transfer did not start the sequencer");

endmodule

// File: tb/sv/tb_positional_list_insert_erase.sv
module tb_positional_list_insert_erase;
   import plie_pkg::*;

   // op code 3 is not decoded by the block; it must answer ok and change nothing
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RESET_CYCLES = 6;
   // longest shift moves 127 entries; settle a little after draining
   localparam int CFG_SETTLE   = 4;
   localparam int END_WAIT     = 300;
   // receiver hold-off used once to back the block up into its request side
   localparam int LONG_HOLD    = 400;
   // cycles without any transfer or register write before the run is abandoned
   localparam int IDLE_LIMIT   = 4000;

   typedef struct packed {
      logic [WORD_W-1:0] read_value;
      logic [7:0]        length;
      logic [1:0]        status;
   } list_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CAP} row_kind_type;

   // one directed row: a request, or a capacity write whose value rides in pos
   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        op;
      logic [7:0]        pos;
      logic [WORD_W-1:0] word;
      logic              typed;
      list_rsp_type      want;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [7:0]   csr_wdata = 8'd0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;   // [7:0] position, [71:8] value
   logic [1:0]   req_tuser = '0;   // [1:0] op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;        // [63:0] read_value, [71:64] length,
                                   // [73:72] status, [79:74] zero

   positional_list_insert_erase u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // List predictor: shadow copy of the entries, the count and the limit
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] list_words [DEPTH];
   int                list_len = 0;
   int                peak_len = 0;
   logic [7:0]        cap_limit = CAP_RESET;

   list_rsp_type answers_due [$];

   int req_count = 0;
   int rsp_count = 0;
   int cap_writes = 0;
   int mismatch_count = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   int burst_left = 0;
   int gap_len = 0;

   function automatic list_rsp_type apply_list_op(input logic [1:0] op, input logic [7:0] pos,
                                                  input logic [WORD_W-1:0] word);
      list_rsp_type r;
      int           limit;
      int           slot;
      int           i;
      r = '0;
      r.status = ST_OK;
      // capacity above the memory depth is clamped to the depth
      limit = (int'(cap_limit) < DEPTH) ? int'(cap_limit) : DEPTH;
      case (op)
         OP_INSERT: begin
            // the full check wins over the position check
            if (list_len >= limit) begin
               r.status = ST_FULL;
            end else if (pos == 8'd0) begin
               r.status = ST_BADPOS;
            end else begin
               // positions past the end append
               slot = int'(pos) - 1;
               if (slot > list_len) slot = list_len;
               for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
               list_words[slot] = word;
               list_len++;
               if (list_len > peak_len) peak_len = list_len;
            end
         end
         OP_ERASE: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // clamp the position into 1..length
               slot = int'(pos);
               if (slot < 1) slot = 1;
               if (slot > list_len) slot = list_len;
               for (i = slot - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         OP_READ: begin
            if (pos == 8'd0 || int'(pos) > list_len) r.status = ST_BADPOS;
            else r.read_value = list_words[int'(pos) - 1];
         end
         default: ;
      endcase
      r.length = list_len[7:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Directed rows, starting from reset (capacity 99, empty list)
   // ------------------------------------------------------------------
   localparam int DIR_ROWS = 27;
   localparam logic [WORD_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [WORD_W-1:0] TOP_LOW  = 64'h8000_0000_0000_0001;

   stim_row_type dir_table [DIR_ROWS] = '{
      // empty list: read, erase and insert at 0 are refused, unused op is a no-op
      '{ROW_REQ, OP_READ,   8'd1,   64'd0,                 1'b1, '{64'd0, 8'd0, ST_BADPOS}},
      '{ROW_REQ, OP_ERASE,  8'd1,   64'd0,                 1'b1, '{64'd0, 8'd0, ST_EMPTY}},
      '{ROW_REQ, OP_UNUSED, 8'd5,   ALL_ONES,              1'b1, '{64'd0, 8'd0, ST_OK}},
      '{ROW_REQ, OP_INSERT, 8'd0,   64'h0123_4567_89AB_CDEF, 1'b1, '{64'd0, 8'd0, ST_BADPOS}},
      // build a three-entry list: head insert, far append, head insert
      '{ROW_REQ, OP_INSERT, 8'd1,   ALL_ONES,              1'b1, '{64'd0, 8'd1, ST_OK}},
      '{ROW_REQ, OP_INSERT, 8'd255, 64'd0,                 1'b1, '{64'd0, 8'd2, ST_OK}},
      '{ROW_REQ, OP_INSERT, 8'd1,   TOP_LOW,               1'b1, '{64'd0, 8'd3, ST_OK}},
      '{ROW_REQ, OP_READ,   8'd1,   64'd0,                 1'b1, '{TOP_LOW, 8'd3, ST_OK}},
      '{ROW_REQ, OP_READ,   8'd2,   ALL_ONES,              1'b1, '{ALL_ONES, 8'd3, ST_OK}},
      '{ROW_REQ, OP_READ,   8'd3,   64'd0,                 1'b1, '{64'd0, 8'd3, ST_OK}},
      '{ROW_REQ, OP_READ,   8'd4,   64'd0,                 1'b1, '{64'd0, 8'd3, ST_BADPOS}},
      '{ROW_REQ, OP_READ,   8'd0,   64'd0,                 1'b1, '{64'd0, 8'd3, ST_BADPOS}},
      // mid insert, then erases clamped from below and from above
      '{ROW_REQ, OP_INSERT, 8'd2,   64'h5555_5555_5555_5555, 1'b0, '0},
      '{ROW_REQ, OP_ERASE,  8'd0,   64'd0,                 1'b0, '0},
      '{ROW_REQ, OP_ERASE,  8'd255, 64'd0,                 1'b0, '0},
      '{ROW_REQ, OP_READ,   8'd128, 64'd0,                 1'b1, '{64'd0, 8'd2, ST_BADPOS}},
      '{ROW_REQ, OP_READ,   8'd1,   64'd0,                 1'b0, '0},
      // capacity below the length: inserts refused, full before bad position
      '{ROW_CAP, OP_INSERT, 8'd1,   64'd0,                 1'b0, '0},
      '{ROW_REQ, OP_INSERT, 8'd1,   64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{64'd0, 8'd2, ST_FULL}},
      '{ROW_REQ, OP_ERASE,  8'd1,   64'd0,                 1'b0, '0},
      '{ROW_REQ, OP_INSERT, 8'd0,   ALL_ONES,              1'b1, '{64'd0, 8'd1, ST_FULL}},
      // zero capacity refuses every insert
      '{ROW_CAP, OP_INSERT, 8'd0,   64'd0,                 1'b0, '0},
      '{ROW_REQ, OP_ERASE,  8'd128, 64'd0,                 1'b0, '0},
      '{ROW_REQ, OP_INSERT, 8'd1,   ALL_ONES,              1'b1, '{64'd0, 8'd0, ST_FULL}},
      // capacity above the depth behaves as the depth
      '{ROW_CAP, OP_INSERT, 8'd255, 64'd0,                 1'b0, '0},
      '{ROW_REQ, OP_INSERT, 8'd200, 64'hDEAD_BEEF_0BAD_F00D, 1'b1, '{64'd0, 8'd1, ST_OK}},
      '{ROW_REQ, OP_READ,   8'd1,   64'd0,                 1'b0, '0}
   };

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one request and hold it until the transfer; predict on transfer.
   // Bursts of random length end in a random gap with valid low, or in none.
   task automatic send_item(input logic [1:0] op, input logic [7:0] pos,
                            input logic [WORD_W-1:0] word, input logic typed,
                            input list_rsp_type want);
      list_rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {word, pos};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(op, pos, word);
      answers_due.push_back(typed ? want : predicted);
      req_count++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap_len > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Drop valid and wait for every outstanding response, then settle.
   task automatic drain_list;
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (CFG_SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [7:0] cap);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_limit = cap;
      cap_writes++;
   endtask

   // One random phase at a given capacity. Positions lean toward the live
   // range of the list, with some full-field values, zero and the edges.
   task automatic run_phase(input logic [7:0] cap, input int n_items,
                            input int insert_pct, input int erase_pct);
      int                roll;
      logic [1:0]        op;
      logic [7:0]        pos;
      logic [WORD_W-1:0] word;
      drain_list();
      write_capacity(cap);
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < insert_pct) op = OP_INSERT;
         else if (roll < insert_pct + erase_pct) op = OP_ERASE;
         else if (roll < 96) op = OP_READ;
         else op = OP_UNUSED;
         case ($urandom_range(0, 9))
            0: pos = 8'($urandom_range(0, 255));
            1: pos = 8'd0;
            2: pos = 8'(list_len);
            3: pos = 8'(list_len + 1);
            default: pos = 8'($urandom_range(1, list_len + 1));
         endcase
         word = {$urandom, $urandom};
         send_item(op, pos, word, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // Response side: stall pattern with one long hold-off
   // ------------------------------------------------------------------
   initial begin : rsp_stall
      int  mode;
      int  mode_left;
      logic held_off;
      mode = 0;
      mode_left = 0;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         // hold off once while requests are still being offered
         if (!reset && !held_off && rsp_count >= 300 && req_tvalid) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(8, 64);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Compare each response transfer with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      list_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value = rsp_tdata[63:0];
         got.length     = rsp_tdata[71:64];
         got.status     = rsp_tdata[73:72];
         rsp_count++;
         status_seen[got.status]++;
         if (answers_due.size() == 0) begin
            $display("%0t: response with none expected: got %h", $time, got);
            mismatch_count++;
         end else begin
            want = answers_due.pop_front();
            if (got.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h got %h", $time,
                        want.read_value, got.read_value);
               mismatch_count++;
            end
            if (got.length !== want.length) begin
               $display("%0t: length expected %0d got %0d", $time, want.length, got.length);
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
               mismatch_count++;
            end
         end
      end
   end

   // Abandon the run when nothing moves for too long.
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                     $time, idle_cycles, answers_due.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : main_seq
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table; capacity rows wait for the block to go idle
      foreach (dir_table[i]) begin
         if (dir_table[i].kind == ROW_CAP) begin
            drain_list();
            write_capacity(dir_table[i].pos);
         end else begin
            send_item(dir_table[i].op, dir_table[i].pos, dir_table[i].word,
                      dir_table[i].typed, dir_table[i].want);
         end
      end

      // random phases: small lists mostly, one fill to the depth, then back down
      run_phase(8'd8,   200, 45, 30);
      run_phase(8'd1,   120, 45, 30);
      run_phase(8'd0,    40, 50, 20);
      run_phase(8'd128, 300, 70, 10);
      run_phase(8'd255, 200, 45, 35);
      run_phase(8'd99,  200, 20, 60);
      run_phase(8'd3,   150, 40, 40);
      run_phase(8'd16,  200, 45, 30);
      run_phase(8'd99,  200, 45, 30);

      // sweep up: wait for all responses, then watch for strays
      drain_list();
      repeat (END_WAIT) @(posedge clock);

      $display("covered %0d requests, %0d responses, %0d capacity writes, longest list %0d",
               req_count, rsp_count, cap_writes, peak_len);
      $display("status counts: ok %0d, full %0d, bad position %0d, empty %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatch_count == 0 && answers_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
